>>> design/hse_pkg.sv
package hse_pkg;

    localparam int NUM_SYMBOLS_DEF  = 128;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Packer geometry: one result carries seven bits, so at most six wait.
    localparam int GROUP_BITS = 7;
    localparam int PEND_BITS  = 6;
    localparam int SYM_BITS   = 7;
    localparam int CODE_BITS  = 32;
    localparam int LEN_BITS   = 6;
    localparam int CNT_BITS   = 3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic table_write;  // write the accepted load item into the table
        logic lookup;       // read the table for the accepted encode item
        logic start;        // load the shift register from the table read
        logic emit_data;    // send the top seven bits as a full result
        logic emit_error;   // send the unknown symbol result
        logic emit_flush;   // send the pending bits and clear them
        logic commit;       // keep the leftover bits as pending, no result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;          // looked-up symbol is in range and valid
        logic rem_ge7;      // at least one full result is left
        logic rem_last;     // the next full result is the last one
        logic pend_nz;      // bits are waiting for a flush
        logic out_free;     // the output register can take a result
    } dp_status_t;

endpackage

>>> design/hse_ctrl.sv
module hse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic [1:0]            opcode,
    input  hse_pkg::dp_status_t   status,
    output logic                  s_tready,
    output hse_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT,
        ST_ERROR,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tready_reg;
    logic   accept;

    assign s_tready = tready_reg;
    assign accept   = s_tvalid && tready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (hse_pkg::opcode_t'(opcode))
                        hse_pkg::OP_LOAD:
                        begin
                            cmd.table_write = 1'b1;
                        end
                        hse_pkg::OP_ENCODE:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        hse_pkg::OP_FLUSH:
                        begin
                            if (status.pend_nz)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (status.hit)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ERROR;
                end
            end
            ST_EMIT:
            begin
                if (!status.rem_ge7)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    if (status.rem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_error = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tready_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            tready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

>>> design/hse_datapath.sv
module hse_datapath #(
    parameter int NUM_SYMBOLS  = hse_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hse_pkg::SYM_BITS-1:0]  symbol,
    input  logic [hse_pkg::CODE_BITS-1:0] code_value,
    input  logic [hse_pkg::LEN_BITS-1:0]  code_length,
    input  hse_pkg::ctrl_cmd_t            cmd,
    output hse_pkg::dp_status_t           status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [hse_pkg::GROUP_BITS-1:0] packed_bits,
    output logic [hse_pkg::CNT_BITS-1:0]  bit_count,
    output logic                          run_end,
    output logic                          unknown_symbol
);

    localparam int IW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int XW = (IW > hse_pkg::SYM_BITS) ? IW : hse_pkg::SYM_BITS;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int WW = MAX_CODE_LEN + hse_pkg::PEND_BITS;
    localparam int RW = $clog2(WW + 1);
    localparam int GB = hse_pkg::GROUP_BITS;
    localparam int PB = hse_pkg::PEND_BITS;

    // Code table: codes are kept left-aligned so bits above the length drop out.
    logic [MAX_CODE_LEN-1:0] mem_code [NUM_SYMBOLS];
    logic [LW-1:0]           mem_len  [NUM_SYMBOLS];
    logic [MAX_CODE_LEN-1:0] rd_code_reg;
    logic [LW-1:0]           rd_len_reg;
    logic [NUM_SYMBOLS-1:0]  valid_reg;
    logic                    hit_reg;

    logic [XW-1:0]              sym_wide;
    logic [IW-1:0]              idx;
    logic                       in_range;
    logic [hse_pkg::LEN_BITS-1:0] len_clamped;
    logic [MAX_CODE_LEN-1:0]    code_left;

    // Packer state. Pending bits are held left-aligned.
    logic [PB-1:0]                 pend_reg;
    logic [hse_pkg::CNT_BITS-1:0]  pend_cnt_reg;
    logic [WW-1:0]                 work_reg;
    logic [RW-1:0]                 rem_reg;
    logic [WW-1:0]                 work_start;
    logic [WW-1:0]                 work_shifted;
    logic [RW-1:0]                 rem_after;

    logic                          out_valid_reg;
    logic [GB-1:0]                 packed_reg;
    logic [hse_pkg::CNT_BITS-1:0]  count_reg;
    logic                          last_reg;
    logic                          unknown_reg;

    assign sym_wide = XW'(symbol);
    assign idx      = sym_wide[IW-1:0];
    assign in_range = ({1'b0, sym_wide} < (XW + 1)'(NUM_SYMBOLS));

    assign len_clamped = (code_length > hse_pkg::LEN_BITS'(MAX_CODE_LEN))
                       ? hse_pkg::LEN_BITS'(MAX_CODE_LEN) : code_length;
    assign code_left   = MAX_CODE_LEN'(code_value)
                         << (hse_pkg::LEN_BITS'(MAX_CODE_LEN) - len_clamped);

    always_ff @(posedge clk)
    begin
        if (cmd.table_write && in_range && (code_length != '0))
        begin
            mem_code[idx] <= code_left;
            mem_len[idx]  <= LW'(len_clamped);
        end
        if (cmd.lookup)
        begin
            rd_code_reg <= mem_code[idx];
            rd_len_reg  <= mem_len[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.table_write && in_range)
            begin
                valid_reg[idx] <= (code_length != '0);
            end
            if (cmd.lookup)
            begin
                hit_reg <= in_range && valid_reg[idx];
            end
        end
    end

    // New code goes right behind the pending bits.
    assign work_start   = {pend_reg, {MAX_CODE_LEN{1'b0}}}
                        | ({rd_code_reg, {PB{1'b0}}} >> pend_cnt_reg);
    assign work_shifted = work_reg << GB;
    assign rem_after    = rem_reg - RW'(GB);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            work_reg <= work_start;
            rem_reg  <= RW'(pend_cnt_reg) + RW'(rd_len_reg);
        end
        else if (cmd.emit_data)
        begin
            work_reg <= work_shifted;
            rem_reg  <= rem_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pend_reg     <= work_reg[WW-1 -: PB];
            pend_cnt_reg <= rem_reg[hse_pkg::CNT_BITS-1:0];
        end
        else if (cmd.emit_data && status.rem_last)
        begin
            pend_reg     <= work_shifted[WW-1 -: PB];
            pend_cnt_reg <= rem_after[hse_pkg::CNT_BITS-1:0];
        end
        else if (cmd.emit_flush)
        begin
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_data || cmd.emit_error || cmd.emit_flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_data)
        begin
            packed_reg  <= work_reg[WW-1 -: GB];
            count_reg   <= hse_pkg::CNT_BITS'(GB);
            last_reg    <= status.rem_last;
            unknown_reg <= 1'b0;
        end
        else if (cmd.emit_error)
        begin
            packed_reg  <= '0;
            count_reg   <= '0;
            last_reg    <= 1'b1;
            unknown_reg <= 1'b1;
        end
        else if (cmd.emit_flush)
        begin
            packed_reg  <= {pend_reg, 1'b0};
            count_reg   <= pend_cnt_reg;
            last_reg    <= 1'b1;
            unknown_reg <= 1'b0;
        end
    end

    assign status.hit      = hit_reg;
    assign status.rem_ge7  = (rem_reg >= RW'(GB));
    assign status.rem_last = (rem_reg < RW'(2 * GB));
    assign status.pend_nz  = (pend_cnt_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign packed_bits    = packed_reg;
    assign bit_count      = count_reg;
    assign run_end        = last_reg;
    assign unknown_symbol = unknown_reg;

endmodule

>>> design/huffman_symbol_encoder_7bit.sv
// Huffman symbol encoder with a loadable code table and a seven-bit packer. Each
// input item carries an opcode in s_tuser: a load item writes one symbol's code
// (right-aligned, first bit most significant) and length into the table, and a
// length of zero invalidates the entry; an encode item appends the symbol's code
// to the packer, and every seven gathered bits leave as one result item with the
// first bit in bit six; a flush item sends any remaining bits left-aligned with
// their true count. Encoding a symbol that has no valid entry gives a single
// result item with unknown_symbol set and changes nothing. m_tlast marks the last
// result item caused by an input item. The table read is registered, and the shift
// register then sends one seven-bit group per cycle while the output is not
// stalled; a longest code can yield five result items. s_tready stays low until
// an input item is finished, so no new item is taken before then. Valid marks are
// cleared by reset at once, so the block is ready as soon as reset is released.
module huffman_symbol_encoder_7bit #(
    parameter int NUM_SYMBOLS  = hse_pkg::NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from lowest: symbol [6:0], code_value [38:7], code_length [44:39],
    // zero fill [47:45].
    input  logic [47:0] s_tdata,
    // Bits from lowest: opcode [1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from lowest: packed_bits [6:0], bit_count [9:7], zero fill [15:10].
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // Bits from lowest: unknown_symbol [0].
    output logic        m_tuser
);

    hse_pkg::ctrl_cmd_t  cmd;
    hse_pkg::dp_status_t status;

    logic [hse_pkg::GROUP_BITS-1:0] packed_bits;
    logic [hse_pkg::CNT_BITS-1:0]   bit_count;

    hse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    hse_datapath #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .symbol         (s_tdata[6:0]),
        .code_value     (s_tdata[38:7]),
        .code_length    (s_tdata[44:39]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .packed_bits    (packed_bits),
        .bit_count      (bit_count),
        .run_end        (m_tlast),
        .unknown_symbol (m_tuser)
    );

    assign m_tdata = {6'b0, bit_count, packed_bits};

    // An unknown symbol result is empty and always ends its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[9:0] == 10'd0))
        else $error("unknown symbol result is not an empty last item");

    // Only the last result of an item may carry fewer than seven bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[9:7] == 3'd7))
        else $error("partial group before the end of a run");

    // The controller issues at most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.table_write, cmd.lookup, cmd.start, cmd.emit_data,
                  cmd.emit_error, cmd.emit_flush, cmd.commit}))
        else $error("conflicting datapath commands");

    // A result is only written into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_data || cmd.emit_error || cmd.emit_flush) |-> status.out_free)
        else $error("result overwrites a waiting output item");

endmodule

>>> tb/huffman_symbol_encoder_7bit_test.sv
module huffman_symbol_encoder_7bit_test;

    // The opcode field has one code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed after the last result for stray output to show up.
    localparam int TAIL_CYCLES = 20;

    // One input item as the stream carries it.
    typedef struct {
        logic [1:0]  opcode;
        logic [6:0]  symbol;
        logic [31:0] code_value;
        logic [5:0]  code_length;
        bit          wait_drain;  // hold this item back until all output is in
    } enc_item_t;

    // One packed result item.
    typedef struct {
        logic [6:0] packed_bits;
        logic [2:0] bit_count;
        logic       run_end;
        logic       unknown_symbol;
    } packed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    huffman_symbol_encoder_7bit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Items waiting to be driven, and the item currently on the slave side.
    enc_item_t    pending_items[$];
    enc_item_t    driven_item;
    // Result items predicted but not yet seen on the master side.
    packed_byte_t expected_bytes[$];

    // Shadow of the encoder: the code table with its valid marks and the
    // bits that wait in the packer for a full group or a flush.
    logic [31:0]  shadow_code[hse_pkg::NUM_SYMBOLS_DEF];
    logic [5:0]   shadow_len[hse_pkg::NUM_SYMBOLS_DEF];
    bit           shadow_valid[hse_pkg::NUM_SYMBOLS_DEF];
    logic [5:0]   held_bits = '0;
    int           held_count = 0;

    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           error_count = 0;
    int           quiet_cycles = 0;

    initial
    begin
        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Work out the result items that one accepted input item causes and
    // update the shadow state the same way the block does.
    task automatic predict_encoder(input enc_item_t it);
        packed_byte_t group_q[$];
        packed_byte_t one;
        logic [6:0]   acc;
        logic [31:0]  bits;
        int           len;
        int           cnt;
        begin
            case (it.opcode)
                hse_pkg::OP_LOAD:
                begin
                    if (it.code_length == 0)
                    begin
                        shadow_valid[it.symbol] = 1'b0;
                    end
                    else
                    begin
                        // Overlong lengths are clamped, and bits above the
                        // length never reach the table.
                        len = (it.code_length > hse_pkg::MAX_CODE_LEN_DEF)
                            ? hse_pkg::MAX_CODE_LEN_DEF : it.code_length;
                        shadow_code[it.symbol]  = 32'(((64'd1 << len) - 64'd1) &
                                                      64'(it.code_value));
                        shadow_len[it.symbol]   = 6'(len);
                        shadow_valid[it.symbol] = 1'b1;
                    end
                end
                hse_pkg::OP_ENCODE:
                begin
                    if (!shadow_valid[it.symbol])
                    begin
                        // Unknown symbol: a single error item, packer untouched.
                        one = '{packed_bits: '0, bit_count: '0, run_end: 1'b1,
                                unknown_symbol: 1'b1};
                        expected_bytes.push_back(one);
                    end
                    else
                    begin
                        acc  = 7'(held_bits);
                        cnt  = held_count;
                        bits = shadow_code[it.symbol];
                        for (int i = int'(shadow_len[it.symbol]); i > 0; i--)
                        begin
                            acc = {acc[5:0], bits[i - 1]};
                            cnt++;
                            if (cnt == hse_pkg::GROUP_BITS)
                            begin
                                one = '{packed_bits: acc,
                                        bit_count: 3'(hse_pkg::GROUP_BITS),
                                        run_end: 1'b0, unknown_symbol: 1'b0};
                                group_q.push_back(one);
                                acc = '0;
                                cnt = 0;
                            end
                        end
                        if (group_q.size() > 0)
                        begin
                            group_q[group_q.size() - 1].run_end = 1'b1;
                        end
                        foreach (group_q[k])
                        begin
                            expected_bytes.push_back(group_q[k]);
                        end
                        held_bits  = acc[5:0];
                        held_count = cnt;
                    end
                end
                hse_pkg::OP_FLUSH:
                begin
                    // Remaining bits leave left-aligned; nothing pending means
                    // no item at all.
                    if (held_count != 0)
                    begin
                        one = '{packed_bits: 7'(7'(held_bits) <<
                                                (hse_pkg::GROUP_BITS - held_count)),
                                bit_count: 3'(held_count), run_end: 1'b1,
                                unknown_symbol: 1'b0};
                        expected_bytes.push_back(one);
                        held_bits  = '0;
                        held_count = 0;
                    end
                end
                default:
                begin
                    // The unused opcode is dropped without any effect.
                end
            endcase
        end
    endtask

    function automatic enc_item_t make_item(input logic [1:0] op, input logic [6:0] sym,
                                            input logic [31:0] code, input logic [5:0] len);
        enc_item_t it;
        it.opcode      = op;
        it.symbol      = sym;
        it.code_value  = code;
        it.code_length = len;
        it.wait_drain  = 1'b0;
        return it;
    endfunction

    // Random traffic: mostly encodes of a small pool of loaded symbols, so
    // the packer keeps crossing group boundaries, with reloads, flushes and
    // a little noise (unknown symbols, invalidations, odd lengths, the
    // unused opcode).
    function automatic enc_item_t random_item();
        enc_item_t it;
        int        pick;
        pick = $urandom_range(99);
        it = make_item(hse_pkg::OP_ENCODE, 7'($urandom_range(15)), $urandom(),
                       6'($urandom_range(1, 32)));
        if (pick < 16)
        begin
            it.opcode = hse_pkg::OP_LOAD;
            if ($urandom_range(9) == 0)
            begin
                it.code_length = 6'($urandom_range(63));
            end
            if ($urandom_range(7) == 0)
            begin
                it.symbol = 7'($urandom_range(127));
            end
        end
        else if (pick < 84)
        begin
            if ($urandom_range(19) == 0)
            begin
                it.symbol = 7'($urandom_range(16, 127));
            end
        end
        else if (pick < 96)
        begin
            it.opcode = hse_pkg::OP_FLUSH;
        end
        else
        begin
            it.opcode = OP_UNUSED;
        end
        return it;
    endfunction

    // Wait until every queued item went in and every predicted result came out.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    endtask

    // Slave-side driver. The predictor runs on the item accepted at this
    // edge before a new one is put on the bus. A valid item is never
    // withdrawn; the idle percentage only decides whether a new one starts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_encoder(driven_item);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 &&
                    (!pending_items[0].wait_drain || expected_bytes.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    driven_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, driven_item.code_length, driven_item.code_value,
                                 driven_item.symbol};
                    s_tuser  <= driven_item.opcode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Master-side monitor: each accepted result item is checked against the
    // oldest prediction. The watchdog also lives here.
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item bits=%h count=%0d last=%b unk=%b",
                                              m_tdata[6:0], m_tdata[9:7], m_tlast, m_tuser));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[6:0] !== want.packed_bits || m_tdata[9:7] !== want.bit_count ||
                        m_tlast !== want.run_end || m_tuser !== want.unknown_symbol)
                    begin
                        report_mismatch($sformatf(
                            "got bits=%h count=%0d last=%b unk=%b, want %h %0d %b %b",
                            m_tdata[6:0], m_tdata[9:7], m_tlast, m_tuser,
                            want.packed_bits, want.bit_count, want.run_end,
                            want.unknown_symbol));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        enc_item_t it;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, run without idling on either side.
        // An encode before any load hits an empty table.
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd5, 32'h0, 6'd0));
        // Flush with nothing pending, then the unused opcode with all ones.
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        pending_items.push_back(make_item(OP_UNUSED, 7'd127, 32'hFFFF_FFFF, 6'd63));
        // Overlong length clamps to the longest code; extra code bits are dropped.
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd0, 32'hFFFF_FFFF, 6'd63));
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd127, 32'h0, 6'd1));
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd1, 32'hFFFF_FFF5, 6'd3));
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd2, 32'h1234_5678, 6'd7));
        // Two short codes emit nothing, then a longest code on six pending
        // bits gives the maximum of five result items.
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd1, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd1, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd0, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd127, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd2, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        // A seven-bit code on an empty packer fills exactly one group.
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd2, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        // Zero length invalidates an entry; encoding it is then unknown.
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd1, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd1, 32'h0, 6'd0));
        // An unknown symbol in the middle must leave pending bits alone.
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd0, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd3, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'd3, 32'hAAAA_AAAA, 6'd32));
        pending_items.push_back(make_item(hse_pkg::OP_ENCODE, 7'd3, 32'h0, 6'd0));
        pending_items.push_back(make_item(hse_pkg::OP_FLUSH, 7'd0, 32'h0, 6'd0));
        wait_drained();

        // Give the random pool of symbols fresh codes.
        for (int s = 0; s < 16; s++)
        begin
            pending_items.push_back(make_item(hse_pkg::OP_LOAD, 7'(s), $urandom(),
                                              6'($urandom_range(1, 32))));
        end
        wait_drained();

        // Random part in four idling phases: none, sender idle, receiver
        // stalling, and light idling on both sides.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 14 : 0;
            recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 14 : 0;
            for (int n = 0; n < 18; n++)
            begin
                it = random_item();
                // Midway through a phase the sender waits for the output to drain.
                it.wait_drain = (n == 9);
                pending_items.push_back(it);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/hse_pkg.sv
design/hse_ctrl.sv
design/hse_datapath.sv
design/huffman_symbol_encoder_7bit.sv
tb/huffman_symbol_encoder_7bit_test.sv
